// ----- rtl/core/tvcf_pkg.sv -----
package tvcf_pkg;

    localparam int POS_W = 24;
    localparam int SMP_W = 16;
    localparam int CNT_W = 16;
    localparam int LVL_W = 17;
    localparam int MG_W = 16;

    localparam logic [LVL_W-1:0] UNITY = 17'h10000;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [2:0] ACT_TICK = 3'd0;
    localparam logic [2:0] ACT_PLAY = 3'd1;
    localparam logic [2:0] ACT_STOP = 3'd2;
    localparam logic [2:0] ACT_PAUSE = 3'd3;
    localparam logic [2:0] ACT_RESUME = 3'd4;
    localparam logic [2:0] ACT_SEEK = 3'd5;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_FADEIN = 3'd1;
    localparam logic [2:0] MODE_STEADY = 3'd2;
    localparam logic [2:0] MODE_XFADE = 3'd3;
    localparam logic [2:0] MODE_FADEOUT = 3'd4;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_FADE_LENGTH = 2'd1;
    localparam logic [1:0] REG_FADE_STEP = 2'd2;
    localparam logic [1:0] REG_MASTER_GAIN = 2'd3;

    typedef struct packed {
        logic start;
        logic gain;
        logic mix;
        logic finish;
    } tvcf_cmd_t;

    typedef struct packed {
        logic busy;
    } tvcf_status_t;

endpackage

// ----- rtl/core/tvcf_ctrl.sv -----
module tvcf_ctrl
    import tvcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  logic         out_valid,
    input  logic         out_ready,
    output logic         in_ready,
    output tvcf_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GAIN = 2'd1;
    localparam logic [1:0] ST_MIX = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start = 1'b1;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.gain = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/core/tvcf_datapath.sv -----
module tvcf_datapath
    import tvcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tvcf_cmd_t               cmd,
    input  logic [1:0]              cfg_channels,
    input  logic [CNT_W-1:0]        cfg_fade_length,
    input  logic [LVL_W-1:0]        cfg_fade_step,
    input  logic [MG_W-1:0]         cfg_master_gain,
    input  logic [2:0]              action,
    input  logic [POS_W-1:0]        play_length,
    input  logic [POS_W-1:0]        seek_frame,
    input  logic signed [SMP_W-1:0] active_left,
    input  logic signed [SMP_W-1:0] active_right,
    input  logic signed [SMP_W-1:0] outgoing_left,
    input  logic signed [SMP_W-1:0] outgoing_right,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic signed [SMP_W-1:0] out_left,
    output logic signed [SMP_W-1:0] out_right,
    output logic                    active_valid,
    output logic [POS_W-1:0]        active_position,
    output logic                    outgoing_valid,
    output logic [POS_W-1:0]        outgoing_position,
    output logic [2:0]              play_state
    ,output logic                   accepted
);

    logic [2:0] mode_reg;
    logic a_pres_reg, o_pres_reg, preq_reg;
    logic [POS_W-1:0] a_pos_reg, a_len_reg, o_pos_reg, o_len_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LVL_W-1:0] plvl_reg;

    logic [2:0] act_reg;
    logic [POS_W-1:0] plen_reg, seek_reg;
    logic signed [SMP_W-1:0] al_reg, ar_reg, ol_reg, or_reg;

    logic [LVL_W-1:0] ga_reg, go_reg;
    logic [MG_W+1:0] mg_reg;
    logic signed [SMP_W+LVL_W+1:0] accl_reg, accr_reg;
    logic frozen_reg;

    logic out_valid_reg;
    logic signed [SMP_W-1:0] outl_reg, outr_reg;
    logic acc_reg;

    logic [LVL_W-1:0] step;
    logic [LVL_W-1:0] plvl_new;
    logic [CNT_W+LVL_W-1:0] gprod;
    logic [LVL_W-1:0] g;
    logic [LVL_W+MG_W-1:0] mprod;
    logic a_live, o_live;

    assign step = (cfg_fade_step == '0 || cfg_fade_step > UNITY) ? UNITY : cfg_fade_step;

    always_comb
    begin
        if (preq_reg)
            plvl_new = (plvl_reg > step) ? plvl_reg - step : '0;
        else
            plvl_new = ({1'b0, plvl_reg} + {1'b0, step} > {1'b0, UNITY}) ? UNITY
                       : plvl_reg + step;
    end

    assign gprod = cnt_reg * step;
    assign g = (gprod > {{CNT_W{1'b0}}, UNITY}) ? UNITY : gprod[LVL_W-1:0];
    assign mprod = plvl_reg * cfg_master_gain;
    assign a_live = a_pres_reg && (a_pos_reg < a_len_reg);
    assign o_live = o_pres_reg && (o_pos_reg < o_len_reg);

    function automatic logic signed [SMP_W+LVL_W+1:0] mac(
        input logic signed [SMP_W-1:0] a, input logic signed [SMP_W-1:0] o,
        input logic [LVL_W-1:0] ga, input logic [LVL_W-1:0] go);
        logic signed [SMP_W+LVL_W+1:0] pa, po;
        begin
            pa = $signed(a) * $signed({1'b0, ga});
            po = $signed(o) * $signed({1'b0, go});
            mac = pa + po;
        end
    endfunction

    function automatic logic signed [SMP_W-1:0] scale(
        input logic signed [SMP_W+LVL_W+1:0] acc, input logic [MG_W+1:0] mg);
        logic signed [SMP_W+LVL_W+MG_W+4:0] v;
        logic signed [SMP_W+LVL_W+MG_W+4:0] r;
        begin
            v = acc * $signed({1'b0, mg});
            v = v + $signed({{(SMP_W+LVL_W+MG_W-25){1'b0}}, 1'b1, 29'd0});
            r = v >>> 30;
            if (r > (2**(SMP_W-1)) - 1)
                scale = {1'b0, {(SMP_W-1){1'b1}}};
            else if (r < -(2**(SMP_W-1)))
                scale = {1'b1, {(SMP_W-1){1'b0}}};
            else
                scale = r[SMP_W-1:0];
        end
    endfunction

    function automatic logic [POS_W-1:0] pinc(input logic [POS_W-1:0] p);
        pinc = (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            a_pres_reg <= 1'b0;
            o_pres_reg <= 1'b0;
            preq_reg <= 1'b0;
            a_pos_reg <= '0;
            a_len_reg <= '0;
            o_pos_reg <= '0;
            o_len_reg <= '0;
            cnt_reg <= '0;
            plvl_reg <= UNITY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.start)
            begin
                act_reg <= action;
                plen_reg <= play_length;
                seek_reg <= seek_frame;
                al_reg <= active_left;
                ar_reg <= active_right;
                ol_reg <= outgoing_left;
                or_reg <= outgoing_right;
            end
            if (cmd.gain && act_reg == ACT_TICK)
            begin
                plvl_reg <= plvl_new;
                frozen_reg <= preq_reg && (plvl_new == '0);
                case (mode_reg)
                    MODE_FADEIN:  begin ga_reg <= g; go_reg <= '0; end
                    MODE_STEADY:  begin ga_reg <= UNITY; go_reg <= '0; end
                    MODE_XFADE:   begin ga_reg <= g; go_reg <= UNITY - g; end
                    MODE_FADEOUT: begin ga_reg <= '0; go_reg <= UNITY - g; end
                    default:      begin ga_reg <= '0; go_reg <= '0; end
                endcase
            end
            if (cmd.mix)
            begin
                mg_reg <= (MG_W+2)'((mprod + 33'd32768) >> 16);
                accl_reg <= mac(a_live ? al_reg : '0, o_live ? ol_reg : '0, ga_reg, go_reg);
                accr_reg <= mac(a_live ? ar_reg : '0, o_live ? or_reg : '0, ga_reg, go_reg);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                acc_reg <= 1'b1;
                outl_reg <= '0;
                outr_reg <= '0;
                case (act_reg)
                    ACT_TICK:
                    begin
                        outl_reg <= scale(accl_reg, mg_reg);
                        outr_reg <= cfg_channels[1] ? scale(accr_reg, mg_reg) : '0;
                        if (!frozen_reg)
                        begin : adv
                            logic [POS_W-1:0] ap, op;
                            logic [CNT_W-1:0] c;
                            logic op_pres;
                            ap = a_pres_reg ? pinc(a_pos_reg) : a_pos_reg;
                            op = o_pres_reg ? pinc(o_pos_reg) : o_pos_reg;
                            c = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
                            a_pos_reg <= ap;
                            o_pos_reg <= op;
                            case (mode_reg)
                                MODE_FADEIN:
                                begin
                                    cnt_reg <= c;
                                    if (ap >= a_len_reg)
                                    begin
                                        a_pres_reg <= 1'b0;
                                        mode_reg <= MODE_IDLE;
                                        cnt_reg <= '0;
                                    end
                                    else if (c >= cfg_fade_length)
                                        mode_reg <= MODE_STEADY;
                                end
                                MODE_STEADY:
                                begin
                                    if (ap >= a_len_reg)
                                    begin
                                        a_pres_reg <= 1'b0;
                                        mode_reg <= MODE_IDLE;
                                    end
                                end
                                MODE_XFADE:
                                begin
                                    cnt_reg <= c;
                                    op_pres = o_pres_reg && !(op >= o_len_reg);
                                    if (c >= cfg_fade_length || !op_pres)
                                    begin
                                        o_pres_reg <= 1'b0;
                                        cnt_reg <= '0;
                                        if (a_pres_reg && ap < a_len_reg)
                                            mode_reg <= MODE_STEADY;
                                        else
                                        begin
                                            a_pres_reg <= 1'b0;
                                            mode_reg <= MODE_IDLE;
                                        end
                                    end
                                end
                                MODE_FADEOUT:
                                begin
                                    cnt_reg <= c;
                                    if (c >= cfg_fade_length || !o_pres_reg || op >= o_len_reg)
                                    begin
                                        o_pres_reg <= 1'b0;
                                        cnt_reg <= '0;
                                        mode_reg <= MODE_IDLE;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    ACT_PLAY:
                    begin
                        if (plen_reg == '0)
                            acc_reg <= 1'b0;
                        else
                        begin
                            preq_reg <= 1'b0;
                            plvl_reg <= UNITY;
                            if (mode_reg != MODE_IDLE)
                            begin
                                o_pres_reg <= a_pres_reg;
                                o_len_reg <= a_len_reg;
                                o_pos_reg <= a_pos_reg;
                                mode_reg <= MODE_XFADE;
                            end
                            else
                                mode_reg <= MODE_FADEIN;
                            a_pres_reg <= 1'b1;
                            a_len_reg <= plen_reg;
                            a_pos_reg <= '0;
                            cnt_reg <= '0;
                        end
                    end
                    ACT_STOP:
                    begin
                        if (mode_reg != MODE_IDLE)
                        begin
                            o_pres_reg <= a_pres_reg;
                            o_len_reg <= a_len_reg;
                            o_pos_reg <= a_pos_reg;
                            a_pres_reg <= 1'b0;
                            cnt_reg <= '0;
                            mode_reg <= MODE_FADEOUT;
                        end
                        preq_reg <= 1'b0;
                        plvl_reg <= UNITY;
                    end
                    ACT_PAUSE: preq_reg <= 1'b1;
                    ACT_RESUME: preq_reg <= 1'b0;
                    ACT_SEEK:
                    begin
                        if (a_pres_reg)
                            a_pos_reg <= (seek_reg > a_len_reg) ? a_len_reg : seek_reg;
                        else
                            acc_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left = outl_reg;
    assign out_right = outr_reg;
    assign active_valid = a_pres_reg;
    assign active_position = a_pres_reg ? a_pos_reg : '0;
    assign outgoing_valid = o_pres_reg;
    assign outgoing_position = o_pres_reg ? o_pos_reg : '0;
    assign play_state = mode_reg;
    assign accepted = acc_reg;

endmodule

// ----- rtl/core/two_voice_crossfade_player.sv -----
// an item is captured on acceptance; gains, sums, output follow in that order
// new items wait for a free output and for the four-step sequencer to be idle
// (capture, gain, multiply-accumulate, scale and state update)
// reset: asynchronous active low; idle, voices absent, pause level at unity,
// registers at their documented defaults
module two_voice_crossfade_player
    import tvcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              action,
    input  logic [POS_W-1:0]        play_length,
    input  logic [POS_W-1:0]        seek_frame,
    input  logic signed [SMP_W-1:0] active_left,
    input  logic signed [SMP_W-1:0] active_right,
    input  logic signed [SMP_W-1:0] outgoing_left,
    input  logic signed [SMP_W-1:0] outgoing_right,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SMP_W-1:0] out_left,
    output logic signed [SMP_W-1:0] out_right,
    output logic                    active_valid,
    output logic [POS_W-1:0]        active_position,
    output logic                    outgoing_valid,
    output logic [POS_W-1:0]        outgoing_position,
    output logic [2:0]              play_state,
    output logic                    accepted
);

    logic [1:0] channels_reg;
    logic [CNT_W-1:0] fade_length_reg;
    logic [LVL_W-1:0] fade_step_reg;
    logic [MG_W-1:0] master_gain_reg;
    tvcf_cmd_t cmd;
    logic in_fire;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= 2'd1;
            fade_length_reg <= 16'd441;
            fade_step_reg <= 17'd149;
            master_gain_reg <= 16'd16384;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_CHANNELS: channels_reg <= pwdata[1:0];
                REG_FADE_LENGTH: fade_length_reg <= pwdata[CNT_W-1:0];
                REG_FADE_STEP: fade_step_reg <= pwdata[LVL_W-1:0];
                REG_MASTER_GAIN: master_gain_reg <= pwdata[MG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CHANNELS: prdata = {30'd0, channels_reg};
            REG_FADE_LENGTH: prdata = {16'd0, fade_length_reg};
            REG_FADE_STEP: prdata = {15'd0, fade_step_reg};
            REG_MASTER_GAIN: prdata = {16'd0, master_gain_reg};
            default: prdata = '0;
        endcase
    end

    tvcf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_valid(out_valid),
        .out_ready(out_ready), .in_ready(in_ready), .cmd(cmd)
    );

    tvcf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .cfg_channels(channels_reg), .cfg_fade_length(fade_length_reg),
        .cfg_fade_step(fade_step_reg), .cfg_master_gain(master_gain_reg),
        .action(action), .play_length(play_length), .seek_frame(seek_frame),
        .active_left(active_left), .active_right(active_right),
        .outgoing_left(outgoing_left), .outgoing_right(outgoing_right),
        .out_ready(out_ready), .out_valid(out_valid),
        .out_left(out_left), .out_right(out_right),
        .active_valid(active_valid), .active_position(active_position),
        .outgoing_valid(outgoing_valid), .outgoing_position(outgoing_position),
        .play_state(play_state), .accepted(accepted)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("item taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        !active_valid |-> active_position == '0)
        else $error("absent voice shows a position");

    assert property (@(posedge clk) disable iff (!rst_n)
        play_state == MODE_IDLE |-> !outgoing_valid)
        else $error("outgoing voice left in idle");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import tvcf_pkg::*;

    typedef struct packed {
        logic [2:0]        action;
        logic [POS_W-1:0]  play_length;
        logic [POS_W-1:0]  seek_frame;
        logic [SMP_W-1:0]  act_l;
        logic [SMP_W-1:0]  act_r;
        logic [SMP_W-1:0]  out_l;
        logic [SMP_W-1:0]  out_r;
    } frame_cmd_t;

    typedef struct packed {
        logic [SMP_W-1:0]  mix_l;
        logic [SMP_W-1:0]  mix_r;
        logic              act_v;
        logic [POS_W-1:0]  act_pos;
        logic              og_v;
        logic [POS_W-1:0]  og_pos;
        logic [2:0]        st;
        logic              acc;
    } frame_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] action = '0;
    logic [POS_W-1:0] play_length = '0, seek_frame = '0;
    logic signed [SMP_W-1:0] active_left = '0, active_right = '0;
    logic signed [SMP_W-1:0] outgoing_left = '0, outgoing_right = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SMP_W-1:0] out_left, out_right;
    logic active_valid, outgoing_valid, accepted;
    logic [POS_W-1:0] active_position, outgoing_position;
    logic [2:0] play_state;

    two_voice_crossfade_player dut (.*);

    // predictor state
    logic [1:0]  p_channels = 2'd1;
    logic [15:0] p_fade_len = 16'd441;
    logic [16:0] p_fade_step = 17'd149;
    logic [15:0] p_master = 16'd16384;
    logic [2:0]  p_mode;
    logic        p_a_on, p_o_on, p_pause_req;
    logic [POS_W-1:0] p_a_pos, p_a_len, p_o_pos, p_o_len;
    logic [15:0] p_count;
    logic [16:0] p_pause_lvl;

    frame_cmd_t  pending_items[$];
    frame_res_t  expected_frames[$];
    int n_errors = 0;
    int n_checked = 0;
    int idle_in_pct = 0, stall_out_pct = 0;
    bit hold_out = 1'b0;
    event hold_go;
    int quiet_cycles = 0;
    int n_ticks = 0;

    // item taken at the last rising edge
    logic in_ready_seen = 1'b0;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [15:0] mix_sample(longint a, longint o, longint ga, longint go,
                                               longint mg);
        longint s, r;
        s = (a * ga + o * go) * mg + (longint'(1) << 29);
        r = s >>> 30;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_next(logic [POS_W-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic void count_up();
        if (p_count != 16'hFFFF) p_count = p_count + 1'b1;
    endfunction

    function automatic void advance_voices();
        if (p_a_on) p_a_pos = pos_next(p_a_pos);
        if (p_o_on) p_o_pos = pos_next(p_o_pos);
        case (p_mode)
            MODE_FADEIN: begin
                count_up();
                if (p_a_pos >= p_a_len) begin
                    p_a_on = 0; p_mode = MODE_IDLE; p_count = 0;
                end
                else if (p_count >= p_fade_len) p_mode = MODE_STEADY;
            end
            MODE_STEADY: begin
                if (p_a_pos >= p_a_len) begin
                    p_a_on = 0; p_mode = MODE_IDLE;
                end
            end
            MODE_XFADE: begin
                count_up();
                if (p_o_on && p_o_pos >= p_o_len) p_o_on = 0;
                if (p_count >= p_fade_len || !p_o_on) begin
                    p_o_on = 0; p_count = 0;
                    if (p_a_on && p_a_pos < p_a_len) p_mode = MODE_STEADY;
                    else begin
                        p_a_on = 0; p_mode = MODE_IDLE;
                    end
                end
            end
            MODE_FADEOUT: begin
                count_up();
                if (p_count >= p_fade_len || !p_o_on || p_o_pos >= p_o_len) begin
                    p_o_on = 0; p_count = 0; p_mode = MODE_IDLE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic frame_res_t predict_frame(frame_cmd_t c);
        frame_res_t r;
        longint st, g, ga, go, mg, al, ar, ol, orr;
        bit frozen;
        r = '0;
        r.acc = 1'b1;
        case (c.action)
            ACT_TICK: begin
                st = (p_fade_step == 0 || p_fade_step > UNITY) ? 65536 : p_fade_step;
                if (p_pause_req) p_pause_lvl = (p_pause_lvl > st) ? p_pause_lvl - st : 0;
                else p_pause_lvl = (p_pause_lvl + st > 65536) ? UNITY : p_pause_lvl + st;
                frozen = p_pause_req && p_pause_lvl == 0;
                g = longint'(p_count) * st;
                if (g > 65536) g = 65536;
                ga = 0; go = 0;
                case (p_mode)
                    MODE_FADEIN: ga = g;
                    MODE_STEADY: ga = 65536;
                    MODE_XFADE: begin
                        ga = g; go = 65536 - g;
                    end
                    MODE_FADEOUT: go = 65536 - g;
                    default: ;
                endcase
                mg = (longint'(p_pause_lvl) * p_master + 32768) >>> 16;
                al = 0; ar = 0; ol = 0; orr = 0;
                if (p_a_on && p_a_pos < p_a_len) begin
                    al = $signed(c.act_l); ar = $signed(c.act_r);
                end
                if (p_o_on && p_o_pos < p_o_len) begin
                    ol = $signed(c.out_l); orr = $signed(c.out_r);
                end
                r.mix_l = mix_sample(al, ol, ga, go, mg);
                r.mix_r = (p_channels >= 2) ? mix_sample(ar, orr, ga, go, mg) : '0;
                if (!frozen) advance_voices();
            end
            ACT_PLAY: begin
                if (c.play_length == 0) r.acc = 1'b0;
                else begin
                    p_pause_req = 0; p_pause_lvl = UNITY;
                    if (p_mode != MODE_IDLE) begin
                        p_o_on = p_a_on; p_o_len = p_a_len; p_o_pos = p_a_pos;
                        p_mode = MODE_XFADE;
                    end
                    else p_mode = MODE_FADEIN;
                    p_a_on = 1; p_a_len = c.play_length; p_a_pos = 0; p_count = 0;
                end
            end
            ACT_STOP: begin
                if (p_mode != MODE_IDLE) begin
                    p_o_on = p_a_on; p_o_len = p_a_len; p_o_pos = p_a_pos;
                    p_a_on = 0; p_count = 0; p_mode = MODE_FADEOUT;
                end
                p_pause_req = 0; p_pause_lvl = UNITY;
            end
            ACT_PAUSE: p_pause_req = 1;
            ACT_RESUME: p_pause_req = 0;
            ACT_SEEK: begin
                if (p_a_on) p_a_pos = (c.seek_frame > p_a_len) ? p_a_len : c.seek_frame;
                else r.acc = 1'b0;
            end
            default: ;
        endcase
        r.act_v = p_a_on;
        r.act_pos = p_a_on ? p_a_pos : '0;
        r.og_v = p_o_on;
        r.og_pos = p_o_on ? p_o_pos : '0;
        r.st = p_mode;
        return r;
    endfunction

    // receiver hold-off, counted here
    always begin
        @(hold_go);
        hold_out = 1'b1;
        repeat (200) @(negedge clk);
        hold_out = 1'b0;
    end

    // driver
    always @(negedge clk) begin
        frame_cmd_t c;
        if (rst_n) begin
            if (!in_valid || in_ready_seen) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
                    c = pending_items.pop_front();
                    in_valid <= 1'b1;
                    action <= c.action;
                    play_length <= c.play_length;
                    seek_frame <= c.seek_frame;
                    active_left <= c.act_l;
                    active_right <= c.act_r;
                    outgoing_left <= c.out_l;
                    outgoing_right <= c.out_r;
                end
                else in_valid <= 1'b0;
            end
            out_ready <= hold_out ? 1'b0 : ($urandom_range(99) >= stall_out_pct);
        end
    end

    // monitor, predictor fed on acceptance
    always @(posedge clk) begin
        frame_cmd_t c;
        frame_res_t got, want;
        in_ready_seen <= in_valid && in_ready;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (in_valid && in_ready) begin
                c = '{action, play_length, seek_frame, active_left, active_right,
                      outgoing_left, outgoing_right};
                if (action == ACT_TICK) n_ticks <= n_ticks + 1;
                expected_frames.push_back(predict_frame(c));
            end
            if (out_valid && out_ready) begin
                got = '{out_left, out_right, active_valid, active_position, outgoing_valid,
                        outgoing_position, play_state, accepted};
                n_checked <= n_checked + 1;
                if (expected_frames.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10) $display("unexpected result %h", got);
                end
                else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        n_errors <= n_errors + 1;
                        if (n_errors < 10) begin
                            $display("mismatch: exp l=%0d r=%0d av=%b ap=%0d ov=%b op=%0d st=%0d acc=%b",
                                $signed(want.mix_l), $signed(want.mix_r), want.act_v,
                                want.act_pos, want.og_v, want.og_pos, want.st, want.acc);
                            $display("          got l=%0d r=%0d av=%b ap=%0d ov=%b op=%0d st=%0d acc=%b",
                                $signed(got.mix_l), $signed(got.mix_r), got.act_v,
                                got.act_pos, got.og_v, got.og_pos, got.st, got.acc);
                        end
                    end
                end
            end
            if (quiet_cycles > 20000) begin
                $display("timeout");
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic frame_cmd_t make_item(logic [2:0] a, logic [POS_W-1:0] len,
                                             logic [POS_W-1:0] sk);
        frame_cmd_t c;
        c.action = a;
        c.play_length = len;
        c.seek_frame = sk;
        c.act_l = $urandom; c.act_r = $urandom;
        c.out_l = $urandom; c.out_r = $urandom;
        return c;
    endfunction

    function automatic frame_cmd_t random_item();
        int k;
        logic [POS_W-1:0] len;
        k = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(60));
        if (k < 70) return make_item(ACT_TICK, $urandom, $urandom);
        if (k < 78) return make_item(ACT_PLAY, len, $urandom);
        if (k < 83) return make_item(ACT_STOP, $urandom, $urandom);
        if (k < 88) return make_item(ACT_PAUSE, $urandom, $urandom);
        if (k < 93) return make_item(ACT_RESUME, $urandom, $urandom);
        if (k < 98) return make_item(ACT_SEEK, $urandom, ($urandom_range(3) == 0) ?
                                     POS_W'($urandom) : POS_W'($urandom_range(70)));
        return make_item(3'($urandom_range(7, 6)), $urandom, $urandom);
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CHANNELS: p_channels = val[1:0];
            REG_FADE_LENGTH: p_fade_len = val[15:0];
            REG_FADE_STEP: p_fade_step = val[16:0];
            default: p_master = val[15:0];
        endcase
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_items.size() > 0 || in_valid || expected_frames.size() > 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        idle_in_pct = idle_pct;
        stall_out_pct = stall_pct;
        repeat (n) pending_items.push_back(random_item());
        drain();
    endtask

    initial begin
        p_mode = MODE_IDLE;
        p_a_on = 0; p_o_on = 0; p_pause_req = 0;
        p_a_pos = 0; p_a_len = 0; p_o_pos = 0; p_o_len = 0;
        p_count = 0; p_pause_lvl = UNITY;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: rejects, every action, extremes of samples
        pending_items.push_back(make_item(ACT_SEEK, 0, 5));
        pending_items.push_back(make_item(ACT_PLAY, 0, 0));
        pending_items.push_back(make_item(ACT_STOP, 0, 0));
        pending_items.push_back(make_item(ACT_PLAY, 3, 0));
        pending_items.push_back('{ACT_TICK, 24'd0, 24'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
        pending_items.push_back(make_item(ACT_PLAY, POS_MAX, 0));
        pending_items.push_back('{ACT_TICK, 24'd0, 24'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
        pending_items.push_back(make_item(ACT_SEEK, 0, POS_MAX));
        pending_items.push_back(make_item(ACT_SEEK, 0, POS_MAX - 1));
        repeat (3) pending_items.push_back(make_item(ACT_TICK, 0, 0));
        pending_items.push_back(make_item(ACT_PAUSE, 0, 0));
        repeat (3) pending_items.push_back(make_item(ACT_TICK, 0, 0));
        pending_items.push_back(make_item(ACT_RESUME, 0, 0));
        pending_items.push_back(make_item(ACT_TICK, 0, 0));
        pending_items.push_back(make_item(ACT_STOP, 0, 0));
        pending_items.push_back(make_item(ACT_TICK, 0, 0));
        pending_items.push_back(make_item(3'd6, 0, 0));
        pending_items.push_back(make_item(3'd7, POS_MAX, POS_MAX));
        drain();

        apb_write(REG_CHANNELS, 2);
        apb_write(REG_FADE_LENGTH, 4);
        apb_write(REG_FADE_STEP, 16384);
        apb_write(REG_MASTER_GAIN, 16'hFFFF);
        run_phase(300, 0, 0);

        apb_write(REG_CHANNELS, 1);
        apb_write(REG_FADE_LENGTH, 1);
        apb_write(REG_FADE_STEP, 0);
        apb_write(REG_MASTER_GAIN, 0);
        run_phase(200, 84, 0);

        apb_write(REG_CHANNELS, 3);
        apb_write(REG_FADE_LENGTH, 16'hFFFF);
        apb_write(REG_FADE_STEP, 17'h1FFFF);
        apb_write(REG_MASTER_GAIN, 40000);
        run_phase(200, 0, 84);

        apb_write(REG_CHANNELS, 0);
        apb_write(REG_FADE_LENGTH, 10);
        apb_write(REG_FADE_STEP, 6554);
        apb_write(REG_MASTER_GAIN, 16384);
        run_phase(300, 36, 36);

        // receiver held off while the sender keeps offering items
        apb_write(REG_CHANNELS, 2);
        apb_write(REG_FADE_LENGTH, 7);
        apb_write(REG_FADE_STEP, 1);
        apb_write(REG_MASTER_GAIN, 20000);
        idle_in_pct = 0; stall_out_pct = 0;
        -> hold_go;
        repeat (40) pending_items.push_back(random_item());
        drain();
        run_phase(300, 0, 0);

        apb_write(REG_FADE_LENGTH, 3);
        apb_write(REG_FADE_STEP, 65536);
        run_phase(200, 36, 36);

        $display("covered %0d results (%0d ticks) over mono/stereo, gain and fade extremes",
                 n_checked, n_ticks);
        if (n_errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
